// ----- src/kvt_pkg.sv -----
// Package for the compacting key/value table: field widths, operation and
// status codes, sequencer states and the command bundle sent to the cells.
// No dependencies.
`default_nettype none

package kvt_pkg;

  // Fixed widths of the request and result fields.
  localparam int OP_W          = 2;
  localparam int KEY_FIELD_W   = 32;
  localparam int VALUE_FIELD_W = 32;
  localparam int STATUS_W      = 2;
  localparam int COUNT_FIELD_W = 7;

  // Operation codes carried by a request.
  typedef enum logic [OP_W-1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } kvt_op_t;

  // Status codes carried by a result.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } kvt_status_t;

  // Sequencer states: waiting for a request, or committing one.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } kvt_state_t;

  // Command broadcast from the sequencer to every cell.
  typedef struct packed {
    logic lookup;   // compare the incoming key and latch the match
    logic update;   // matching cell takes the new value
    logic append;   // tail cell takes the new pair
    logic remove;   // cells at or above the match take their neighbour's pair
  } kvt_cmd_t;

endpackage

`default_nettype wire

// ----- src/kvt_in_if.sv -----
// Request channel of the compacting key/value table.
// Depends on kvt_pkg for the field widths.
`default_nettype none

interface kvt_in_if;
  logic                                valid;
  logic                                ready;
  logic [kvt_pkg::OP_W-1:0]            operation;
  logic [kvt_pkg::KEY_FIELD_W-1:0]     lookup_key;
  logic [kvt_pkg::VALUE_FIELD_W-1:0]   write_value;

  modport source (output valid, operation, lookup_key, write_value, input ready);
  modport sink   (input valid, operation, lookup_key, write_value, output ready);
endinterface

`default_nettype wire

// ----- src/kvt_out_if.sv -----
// Result channel of the compacting key/value table.
// Depends on kvt_pkg for the field widths.
`default_nettype none

interface kvt_out_if;
  logic                                valid;
  logic                                ready;
  logic [kvt_pkg::VALUE_FIELD_W-1:0]   read_value;
  logic [kvt_pkg::STATUS_W-1:0]        status;
  logic [kvt_pkg::COUNT_FIELD_W-1:0]   entry_count;

  modport source (output valid, read_value, status, entry_count, input ready);
  modport sink   (input valid, read_value, status, entry_count, output ready);
endinterface

`default_nettype wire

// ----- src/kvt_cell.sv -----
// One slot of the table: holds a key and a value, compares the key of a
// new request and hands its pair down to the slot below on a delete.
// Depends on kvt_pkg for the command bundle.
`default_nettype none

module kvt_cell #(
  parameter int KEY_W = 32,
  parameter int VAL_W = 32,
  parameter int CNT_W = 7,
  parameter int IDX   = 0
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire kvt_pkg::kvt_cmd_t cmd,
  input  wire  [CNT_W-1:0]       count,
  input  wire  [KEY_W-1:0]       look_key,
  input  wire  [KEY_W-1:0]       new_key,
  input  wire  [VAL_W-1:0]       new_val,
  input  wire  [KEY_W-1:0]       next_key,
  input  wire  [VAL_W-1:0]       next_val,
  input  wire                    shift_in,
  output logic [KEY_W-1:0]       key_q,
  output logic [VAL_W-1:0]       val_q,
  output logic                   hit,
  output logic                   shift_out,
  output logic [VAL_W-1:0]       rd_val
);

  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic             hit_r, hit_nxt;
  logic             in_range;
  logic             is_tail;

  // The slot holds a live pair only below the fill count.
  assign in_range = (CNT_W'(IDX) < count);
  assign is_tail  = (CNT_W'(IDX) == count);

  // Match flag is latched when a request is taken and held until the next one.
  assign hit_nxt = cmd.lookup ? (in_range && (key_r == look_key)) : hit_r;

  // The delete shift covers the matching slot and every slot above it.
  assign shift_out = shift_in | hit_r;

  assign key_q  = key_r;
  assign val_q  = val_r;
  assign hit    = hit_r;
  assign rd_val = hit_r ? val_r : '0;

  // Pair update: value overwrite, append at the tail, or shift down.
  always_comb begin
    key_nxt = key_r;
    val_nxt = val_r;
    if (cmd.update && hit_r) begin
      val_nxt = new_val;
    end
    if (cmd.append && is_tail) begin
      key_nxt = new_key;
      val_nxt = new_val;
    end
    if (cmd.remove && shift_out) begin
      key_nxt = next_key;
      val_nxt = next_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

  // Pair storage carries no reset.
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    val_r <= val_nxt;
  end

endmodule

`default_nettype wire

// ----- src/compacting_key_value_table.sv -----
// Top level of the compacting key/value table: a row of kvt_cell slots, the
// request sequencer, the fill count and the result register.
// Depends on kvt_pkg, kvt_in_if, kvt_out_if and kvt_cell.
//
//  Channel  Direction  Handshake     Payload
//  in_ch    sink       valid/ready   operation, lookup_key, write_value
//  out_ch   source     valid/ready   read_value, status, entry_count
//
// At the accepting edge every slot compares the key of a request in parallel
// and latches its match; at the commit edge, once a waiting result is taken,
// the match drives the value read, overwrite, append or the one-slot shift of a delete.
// Reset (synchronous, active low) empties the table and the result register.
// A result that is not taken holds the commit cycle; a request is taken while
// the previous result still waits, but the next one waits for its commit.
`default_nettype none

module compacting_key_value_table #(
  parameter int CAPACITY   = 64,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  wire       clk,
  input  wire       rst_n,
  kvt_in_if.sink    in_ch,
  kvt_out_if.source out_ch
);

  localparam int KEY_W = (KEY_BITS < kvt_pkg::KEY_FIELD_W) ? KEY_BITS : kvt_pkg::KEY_FIELD_W;
  localparam int VAL_W = (VALUE_BITS < kvt_pkg::VALUE_FIELD_W) ?
                         VALUE_BITS : kvt_pkg::VALUE_FIELD_W;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  kvt_pkg::kvt_state_t  state_r, state_nxt;
  kvt_pkg::kvt_op_t     op_r;
  logic [KEY_W-1:0]     key_r;
  logic [VAL_W-1:0]     val_r;
  logic [CNT_W-1:0]     count_r, count_nxt;

  logic                                 out_valid_r, out_valid_nxt;
  logic [kvt_pkg::VALUE_FIELD_W-1:0]    out_value_r, out_value_nxt;
  kvt_pkg::kvt_status_t                 out_status_r, out_status_nxt;
  logic [kvt_pkg::COUNT_FIELD_W-1:0]    out_count_r, out_count_nxt;

  kvt_pkg::kvt_cmd_t    cmd;
  logic                 accept;
  logic                 commit;
  logic                 hit_any;
  logic [VAL_W-1:0]     rd_or;
  logic [VAL_W+kvt_pkg::VALUE_FIELD_W-1:0] rd_ext;
  logic [CNT_W+kvt_pkg::COUNT_FIELD_W-1:0] cnt_ext;

  logic [CAPACITY-1:0]  hit_vec;
  logic [CAPACITY:0]    shift_chain;
  logic [KEY_W-1:0]     cell_key [CAPACITY];
  logic [VAL_W-1:0]     cell_val [CAPACITY];
  logic [VAL_W-1:0]     cell_rd  [CAPACITY];

  // Handshakes.
  assign in_ch.ready = (state_r == kvt_pkg::S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign commit      = (state_r == kvt_pkg::S_EXEC) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_value  = out_value_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.entry_count = out_count_r;

  // Row of slots; each hands its pair to the slot below on a delete.
  assign shift_chain[0] = 1'b0;
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int NB = (i + 1 < CAPACITY) ? i + 1 : i;
    kvt_cell #(
      .KEY_W (KEY_W),
      .VAL_W (VAL_W),
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .count     (count_r),
      .look_key  (in_ch.lookup_key[KEY_W-1:0]),
      .new_key   (key_r),
      .new_val   (val_r),
      .next_key  (cell_key[NB]),
      .next_val  (cell_val[NB]),
      .shift_in  (shift_chain[i]),
      .key_q     (cell_key[i]),
      .val_q     (cell_val[i]),
      .hit       (hit_vec[i]),
      .shift_out (shift_chain[i+1]),
      .rd_val    (cell_rd[i])
    );
  end

  // Read value: at most one slot matches, so its masked value is an OR.
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  assign hit_any = |hit_vec;
  assign rd_ext  = {{kvt_pkg::VALUE_FIELD_W{1'b0}}, rd_or};

  // Request register: operation, key and value held for the commit cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= kvt_pkg::kvt_op_t'(in_ch.operation);
      key_r <= in_ch.lookup_key[KEY_W-1:0];
      val_r <= in_ch.write_value[VAL_W-1:0];
    end
  end

  // Sequencer: next state, cell commands, fill count and result.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    cmd            = '0;
    cmd.lookup     = accept;
    cnt_ext        = '0;

    unique case (state_r)
      kvt_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = kvt_pkg::S_EXEC;
        end
      end
      kvt_pkg::S_EXEC: begin
        if (commit) begin
          state_nxt      = kvt_pkg::S_IDLE;
          out_value_nxt  = '0;
          out_status_nxt = kvt_pkg::ST_OK;
          unique case (op_r)
            kvt_pkg::OP_READ: begin
              if (hit_any) begin
                out_value_nxt = rd_ext[kvt_pkg::VALUE_FIELD_W-1:0];
              end else begin
                out_status_nxt = kvt_pkg::ST_MISS;
              end
            end
            kvt_pkg::OP_WRITE: begin
              if (hit_any) begin
                cmd.update = 1'b1;
              end else if (count_r < CNT_W'(CAPACITY)) begin
                cmd.append = 1'b1;
                count_nxt  = count_r + CNT_W'(1);
              end else begin
                out_status_nxt = kvt_pkg::ST_FULL;
              end
            end
            kvt_pkg::OP_DELETE: begin
              if (hit_any) begin
                cmd.remove = 1'b1;
                count_nxt  = count_r - CNT_W'(1);
              end else begin
                out_status_nxt = kvt_pkg::ST_MISS;
              end
            end
            kvt_pkg::OP_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
              count_nxt = count_r;
            end
          endcase
          cnt_ext       = {{kvt_pkg::COUNT_FIELD_W{1'b0}}, count_nxt};
          out_count_nxt = cnt_ext[kvt_pkg::COUNT_FIELD_W-1:0];
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = kvt_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kvt_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  // The fill count never passes the number of slots.
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("fill count beyond capacity");

  // Keys are unique, so at most one live slot matches a request.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == kvt_pkg::S_EXEC) |-> $onehot0(hit_vec))
    else $error("more than one slot matches the key");

  // An accepted request is committed in the following cycle or later.
  assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == kvt_pkg::S_EXEC))
    else $error("accepted request not held for commit");

  // A full status is only reported while every slot is occupied.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == kvt_pkg::ST_FULL)) |-> (count_r == CNT_W'(CAPACITY)))
    else $error("full status with free slots");

  // A delete that commits shortens the table by exactly one pair.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.remove |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("delete did not shorten the table by one");

endmodule

`default_nettype wire

// ----- tb/sv/kvt_table_monitor.sv -----
// Monitor for the compacting key/value table: keeps its own copy of the table,
// predicts the response to every accepted request and compares it field by field.
// Depends on kvt_pkg for the field widths, operation and status codes.
`timescale 1ns / 100ps

module kvt_table_monitor (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [kvt_pkg::OP_W-1:0]          in_operation,
  input  logic [kvt_pkg::KEY_FIELD_W-1:0]   in_lookup_key,
  input  logic [kvt_pkg::VALUE_FIELD_W-1:0] in_write_value,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [kvt_pkg::VALUE_FIELD_W-1:0] out_read_value,
  input  logic [kvt_pkg::STATUS_W-1:0]      out_status,
  input  logic [kvt_pkg::COUNT_FIELD_W-1:0] out_entry_count,
  output int                                mismatch_count,
  output int                                outstanding_results
);
  import kvt_pkg::*;

  localparam int TABLE_SLOTS = 64;

  typedef struct packed {
    logic [VALUE_FIELD_W-1:0] read_value;
    kvt_status_t              status;
    logic [COUNT_FIELD_W-1:0] entry_count;
  } table_response_t;

  // Shadow copy of the table, packed in insertion order.
  logic [KEY_FIELD_W-1:0]   shadow_keys [TABLE_SLOTS];
  logic [VALUE_FIELD_W-1:0] shadow_values [TABLE_SLOTS];
  int                       shadow_fill;

  table_response_t awaited_responses[$];
  int              errors;

  // Applies one request to the shadow table and returns the response it gives.
  function automatic table_response_t apply_table_request(
    kvt_op_t op, logic [KEY_FIELD_W-1:0] key, logic [VALUE_FIELD_W-1:0] value);
    table_response_t resp;
    int              slot;
    resp.read_value = '0;
    resp.status     = ST_OK;
    slot            = -1;
    for (int i = 0; i < shadow_fill; i++) begin
      if (slot < 0 && shadow_keys[i] == key) slot = i;
    end
    case (op)
      OP_READ: begin
        if (slot >= 0) resp.read_value = shadow_values[slot];
        else resp.status = ST_MISS;
      end
      OP_WRITE: begin
        if (slot >= 0) begin
          shadow_values[slot] = value;
        end else if (shadow_fill < TABLE_SLOTS) begin
          shadow_keys[shadow_fill]   = key;
          shadow_values[shadow_fill] = value;
          shadow_fill++;
        end else begin
          resp.status = ST_FULL;
        end
      end
      OP_DELETE: begin
        if (slot >= 0) begin
          // Later pairs move down one slot to close the gap.
          for (int j = slot; j < shadow_fill - 1; j++) begin
            shadow_keys[j]   = shadow_keys[j + 1];
            shadow_values[j] = shadow_values[j + 1];
          end
          shadow_fill--;
        end else begin
          resp.status = ST_MISS;
        end
      end
      default: begin
        shadow_fill = 0;
      end
    endcase
    resp.entry_count = COUNT_FIELD_W'(shadow_fill);
    return resp;
  endfunction

  // Responses are retired before new requests are predicted, since a response
  // accepted at an edge always belongs to an earlier request.
  always @(posedge clk) begin : track_table
    table_response_t got;
    table_response_t want;
    if (!rst_n) begin
      awaited_responses.delete();
      shadow_fill = 0;
      errors      = 0;
      mismatch_count      <= 0;
      outstanding_results <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got.read_value  = out_read_value;
        got.status      = kvt_status_t'(out_status);
        got.entry_count = out_entry_count;
        if (awaited_responses.size() == 0) begin
          $display("%0t: response with no request outstanding: value %h status %0d count %0d",
                   $time, got.read_value, got.status, got.entry_count);
          errors++;
        end else begin
          want = awaited_responses.pop_front();
          if (got.read_value !== want.read_value) begin
            $display("%0t: read_value expected %h actual %h",
                     $time, want.read_value, got.read_value);
            errors++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
          end
          if (got.entry_count !== want.entry_count) begin
            $display("%0t: entry_count expected %0d actual %0d",
                     $time, want.entry_count, got.entry_count);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        awaited_responses.push_back(apply_table_request(kvt_op_t'(in_operation),
                                                        in_lookup_key, in_write_value));
      end
      mismatch_count      <= errors;
      outstanding_results <= awaited_responses.size();
    end
  end

endmodule

// ----- tb/sv/compacting_key_value_table_tb.sv -----
// Testbench top for the compacting key/value table: clock, reset, request
// stimulus, response back-pressure and the verdict.
// Depends on kvt_pkg, kvt_in_if, kvt_out_if, the table itself and kvt_table_monitor.
`timescale 1ns / 100ps

module compacting_key_value_table_tb;
  import kvt_pkg::*;

  localparam int LONG_STALL_CYCLES = 300;
  localparam int QUIET_LIMIT       = 2000;
  localparam int TAIL_CYCLES       = 8;
  localparam int POOL_MAX          = 96;

  typedef enum int {MIX_FILL, MIX_CHURN, MIX_TIGHT} traffic_mix_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int send_idle_pct;
  int recv_idle_pct;
  int long_stall_requests = 0;
  int mismatch_count;
  int outstanding_results;

  logic [KEY_FIELD_W-1:0] key_pool [POOL_MAX];
  int                     pool_size;

  kvt_in_if  in_ch ();
  kvt_out_if out_ch ();

  compacting_key_value_table u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  kvt_table_monitor u_monitor (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_ch.valid),
    .in_ready            (in_ch.ready),
    .in_operation        (in_ch.operation),
    .in_lookup_key       (in_ch.lookup_key),
    .in_write_value      (in_ch.write_value),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_read_value      (out_ch.read_value),
    .out_status          (out_ch.status),
    .out_entry_count     (out_ch.entry_count),
    .mismatch_count      (mismatch_count),
    .outstanding_results (outstanding_results)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Offers one request after a random gap and returns at the edge that takes it.
  task automatic put_request(kvt_op_t op, logic [KEY_FIELD_W-1:0] key,
                             logic [VALUE_FIELD_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.lookup_key  <= key;
    in_ch.write_value <= value;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stops offering requests until every response has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding_results != 0);
  endtask

  function automatic logic [VALUE_FIELD_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly keys from the current pool so that requests hit; now and then a stray key.
  function automatic logic [KEY_FIELD_W-1:0] pick_key();
    if ($urandom_range(19) == 0) return $urandom;
    return key_pool[$urandom_range(pool_size - 1)];
  endfunction

  // Empty-table cases, the extreme keys and values, update, deletes at the
  // head, middle and tail of the table, and clears of an empty and a filled table.
  task automatic run_directed_checks();
    put_request(OP_READ,   32'h0000_0000, 32'h0000_0000);
    put_request(OP_DELETE, 32'h0000_0000, 32'hFFFF_FFFF);
    put_request(OP_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    put_request(OP_WRITE,  32'h0000_0000, 32'h0000_0000);
    put_request(OP_WRITE,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    put_request(OP_WRITE,  32'h1234_5678, 32'hA5A5_A5A5);
    put_request(OP_READ,   32'h0000_0000, 32'hFFFF_FFFF);
    put_request(OP_READ,   32'hFFFF_FFFF, 32'h0000_0000);
    put_request(OP_READ,   32'h1234_5678, 32'h0000_0000);
    put_request(OP_WRITE,  32'h0000_0000, 32'h5A5A_5A5A);
    put_request(OP_READ,   32'h0000_0000, 32'h0000_0000);
    put_request(OP_DELETE, 32'hFFFF_FFFF, 32'h0000_0000);
    put_request(OP_READ,   32'h1234_5678, 32'h0000_0000);
    put_request(OP_READ,   32'hFFFF_FFFF, 32'h0000_0000);
    put_request(OP_DELETE, 32'h0000_0000, 32'h0000_0000);
    put_request(OP_DELETE, 32'h1234_5678, 32'h0000_0000);
    put_request(OP_READ,   32'h1234_5678, 32'h0000_0000);
    put_request(OP_WRITE,  32'h5555_5555, 32'hAAAA_AAAA);
    put_request(OP_WRITE,  32'hAAAA_AAAA, 32'h5555_5555);
    put_request(OP_CLEAR,  32'h0000_0000, 32'h0000_0000);
    put_request(OP_READ,   32'h5555_5555, 32'h0000_0000);
  endtask

  // Random traffic in segments; each segment draws a fresh key pool and a mix
  // that either fills the table to capacity, churns it or hammers a few keys.
  task automatic run_traffic_phase(int send_pct, int recv_pct, int item_total);
    traffic_mix_t mix;
    int           sent;
    int           seg_left;
    int           write_pct;
    int           read_pct;
    int           delete_pct;
    int           roll;
    kvt_op_t      op;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent          = 0;
    seg_left      = 0;
    while (sent < item_total) begin
      if (seg_left == 0) begin
        mix = traffic_mix_t'($urandom_range(2));
        case (mix)
          MIX_FILL: begin
            pool_size = POOL_MAX;
            write_pct = 80; read_pct = 12; delete_pct = 8;
            seg_left  = $urandom_range(100, 160);
          end
          MIX_CHURN: begin
            pool_size = 72;
            write_pct = 40; read_pct = 30; delete_pct = 27;
            seg_left  = $urandom_range(40, 100);
          end
          default: begin
            pool_size = 6;
            write_pct = 35; read_pct = 35; delete_pct = 25;
            seg_left  = $urandom_range(30, 60);
          end
        endcase
        for (int i = 0; i < POOL_MAX; i++) key_pool[i] = $urandom;
      end
      // Halfway through, the response side holds off while requests keep coming.
      if (sent == item_total / 2) long_stall_requests <= long_stall_requests + 1;
      roll = $urandom_range(99);
      if (roll < write_pct) op = OP_WRITE;
      else if (roll < write_pct + read_pct) op = OP_READ;
      else if (roll < write_pct + read_pct + delete_pct) op = OP_DELETE;
      else op = OP_CLEAR;
      put_request(op, pick_key(), pick_value());
      sent++;
      seg_left--;
    end
    drain_results();
  endtask

  // Response side: random back-pressure, or a long hold-off when one is asked for.
  initial begin : response_sink
    int hold_left;
    int stalls_served;
    hold_left     = 0;
    stalls_served = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stalls_served != long_stall_requests) begin
        stalls_served = long_stall_requests;
        hold_left     = LONG_STALL_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Ends the run when no request and no response has moved for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    in_ch.valid       <= 1'b0;
    in_ch.operation   <= OP_READ;
    in_ch.lookup_key  <= '0;
    in_ch.write_value <= '0;
    send_idle_pct = 32;
    recv_idle_pct = 56;
    pool_size     = 1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    run_directed_checks();
    drain_results();
    run_traffic_phase(32, 56, 533);
    run_traffic_phase(56, 32, 533);
    run_traffic_phase(0, 0, 534);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
